// ===== rtl/core/ceq_pkg.sv =====
// ============================================================================
// ceq_pkg
// Shared types and codes of the coalescing event queue.
// ============================================================================
package ceq_pkg;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_COALESCED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_POPPED    = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_MOTION_KIND   = 1'b0,
        REG_OVERFLOW_KIND = 1'b1
    } t_reg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_MRG,
        S_PLACE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    localparam logic [31:0] ABS_FLAG = 32'h0000_0001;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // One stored event.
    typedef struct packed {
        logic [7:0]         kind;
        logic [7:0]         source;
        logic [7:0]         dev_kind;
        logic [31:0]        flags;
        logic [31:0]        dev_number;
        logic [31:0]        hash;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic [63:0]        time_us;
    } t_slot;

    typedef struct packed {
        t_status status;
        t_slot   evt;
    } t_result;

endpackage

// ===== rtl/core/ceq_if.sv =====
// ============================================================================
// ceq_if
// Channel interfaces: event input, result output, register write.
// ============================================================================
interface ceq_event_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         event_kind;
    logic [31:0]        event_flags;
    logic [7:0]         event_source;
    logic [7:0]         device_kind;
    logic [31:0]        device_number;
    logic [31:0]        instance_hash;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [63:0]        time_us;

    modport source (output valid, opcode, event_kind, event_flags, event_source,
                    device_kind, device_number, instance_hash, value_a, value_b,
                    value_c, time_us, input ready);
    modport sink   (input valid, opcode, event_kind, event_flags, event_source,
                    device_kind, device_number, instance_hash, value_a, value_b,
                    value_c, time_us, output ready);
endinterface

interface ceq_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         out_kind;
    logic [31:0]        out_flags;
    logic [7:0]         out_source;
    logic [7:0]         out_device_kind;
    logic [31:0]        out_device_number;
    logic [31:0]        out_instance_hash;
    logic signed [31:0] out_value_a;
    logic signed [31:0] out_value_b;
    logic signed [31:0] out_value_c;
    logic [63:0]        out_time_us;

    modport source (output valid, status, out_kind, out_flags, out_source,
                    out_device_kind, out_device_number, out_instance_hash,
                    out_value_a, out_value_b, out_value_c, out_time_us,
                    input ready);
    modport sink   (input valid, status, out_kind, out_flags, out_source,
                    out_device_kind, out_device_number, out_instance_hash,
                    out_value_a, out_value_b, out_value_c, out_time_us,
                    output ready);
endinterface

interface ceq_cfg_if;
    logic       valid;
    logic       ready;
    logic       reg_index;
    logic [7:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/core/ceq_slot_ram.sv =====
// ============================================================================
// ceq_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ============================================================================
module ceq_slot_ram #(
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  ceq_pkg::t_slot            i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output ceq_pkg::t_slot            o_rdata
);
    import ceq_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ceq_merge.sv =====
// ============================================================================
// ceq_merge
// Match test of a new motion word against the newest slot, and the merge.
// ============================================================================
module ceq_merge (
    input  ceq_pkg::t_slot i_stored,
    input  ceq_pkg::t_slot i_new,
    input  logic [7:0]     i_motion_code,
    output logic           o_hit,
    output ceq_pkg::t_slot o_merged
);
    import ceq_pkg::*;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (s < 33'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return s[31:0];
    endfunction

    assign o_hit = (i_stored.kind == i_motion_code)
                && (i_stored.source == i_new.source)
                && (i_stored.dev_kind == i_new.dev_kind)
                && (i_stored.dev_number == i_new.dev_number)
                && (i_stored.hash == i_new.hash)
                && (i_stored.flags == i_new.flags)
                && (i_stored.value_c == i_new.value_c);

    always_comb begin
        o_merged = i_stored;
        o_merged.time_us = i_new.time_us;
        if ((i_new.flags & ABS_FLAG) != 32'd0) begin
            o_merged.value_a = i_new.value_a;
            o_merged.value_b = i_new.value_b;
        end else begin
            o_merged.value_a = sat_add(i_stored.value_a, i_new.value_a);
            o_merged.value_b = sat_add(i_stored.value_b, i_new.value_b);
        end
    end

endmodule

// ===== rtl/core/coalescing_event_queue.sv =====
// ============================================================================
// coalescing_event_queue
// Ring FIFO of input events with motion coalescing and overflow handling.
// ============================================================================
// Flow: a pop reads the head slot; a non-full push merges or places the word;
// a non-motion push into a full queue scans for the oldest motion word to evict,
// then compacts; all steps are paced by the slot RAM.
// Throughput: one word in flight at a time; a new word is taken on return to idle.
// Reset: synchronous active low; pointers, fill count and overflow record clear,
// the motion kind register resets to 0 and the overflow kind register to 1; slot contents are left as they are.
module coalescing_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ceq_event_if.sink            i_evt,
    ceq_result_if.source         o_res,
    ceq_cfg_if.sink              i_cfg
);
    import ceq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;

    // Logical queue position to RAM address.
    function automatic t_addr phys(t_addr base, t_count k);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(k);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic t_addr inc_addr(t_addr a);
        return (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // Control and bookkeeping.
    t_state  r_state, n_state;
    t_addr   r_rp, n_rp;
    t_addr   r_wp, n_wp;
    t_count  r_fill, n_fill;
    t_count  r_k, n_k;
    logic    r_ovf_pend, n_ovf_pend;
    logic    r_out_valid, n_out_valid;
    logic [7:0] r_motion_code, r_ovf_code;

    // Payload.
    t_slot   r_cmd, n_cmd;
    t_slot   r_ovf, n_ovf;
    t_result r_res, n_res;
    t_result r_out, n_out;

    // RAM port.
    logic    ram_we;
    t_addr   ram_waddr, ram_raddr;
    t_slot   ram_wdata, ram_rdata;

    // Merge unit.
    logic    mrg_hit;
    t_slot   mrg_slot;

    t_slot   in_slot;
    logic    in_accept;
    logic    cmd_motion;
    logic    slot_motion;
    logic    fill_full;
    t_addr   wp_last;
    t_count  k_next;

    assign in_slot.kind       = i_evt.event_kind;
    assign in_slot.source     = i_evt.event_source;
    assign in_slot.dev_kind   = i_evt.device_kind;
    assign in_slot.flags      = i_evt.event_flags;
    assign in_slot.dev_number = i_evt.device_number;
    assign in_slot.hash       = i_evt.instance_hash;
    assign in_slot.value_a    = i_evt.value_a;
    assign in_slot.value_b    = i_evt.value_b;
    assign in_slot.value_c    = i_evt.value_c;
    assign in_slot.time_us    = i_evt.time_us;

    assign i_evt.ready = (r_state == S_IDLE);
    assign in_accept   = i_evt.valid && i_evt.ready;
    assign i_cfg.ready = 1'b1;

    assign cmd_motion  = (r_cmd.kind == r_motion_code);
    assign slot_motion = (ram_rdata.kind == r_motion_code);
    assign fill_full   = (r_fill == CW'(QUEUE_DEPTH));
    assign wp_last     = (r_wp == '0) ? AW'(QUEUE_DEPTH - 1) : r_wp - AW'(1);
    assign k_next      = r_k + CW'(1);

    ceq_slot_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ceq_merge u_merge (
        .i_stored      (ram_rdata),
        .i_new         (r_cmd),
        .i_motion_code (r_motion_code),
        .o_hit         (mrg_hit),
        .o_merged      (mrg_slot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_evt.opcode == OP_POP) begin
                        if (r_ovf_pend || r_fill == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_POP;
                        end
                    end else if (r_fill != '0 && i_evt.event_kind == r_motion_code) begin
                        n_state = S_MRG;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_POP:   n_state = S_DONE;
            S_MRG:   n_state = mrg_hit ? S_DONE : S_PLACE;
            S_PLACE: begin
                if (!fill_full || cmd_motion) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (slot_motion) begin
                    n_state = S_SHIFT_RD;
                end else if (k_next == r_fill) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: n_state = (k_next < r_fill) ? S_SHIFT_WR : S_DONE;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_k         = r_k;
        n_ovf_pend  = r_ovf_pend;
        n_cmd       = r_cmd;
        n_ovf       = r_ovf;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_wp;
        ram_wdata   = r_cmd;
        ram_raddr   = r_rp;

        // Drop the output word once taken; a new one may replace it below.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // Address the head for a pop, the newest slot for a push.
                ram_raddr = (i_evt.opcode == OP_POP) ? r_rp : wp_last;
                if (in_accept) begin
                    n_cmd = in_slot;
                    n_res = '0;
                    if (i_evt.opcode == OP_POP) begin
                        if (r_ovf_pend) begin
                            n_ovf_pend   = 1'b0;
                            n_res.status = ST_POPPED;
                            n_res.evt    = r_ovf;
                            n_res.evt.kind = r_ovf_code;
                        end else if (r_fill == '0) begin
                            n_res.status = ST_EMPTY;
                        end
                    end
                end
            end
            S_POP: begin
                n_res.status = ST_POPPED;
                n_res.evt    = ram_rdata;
                n_rp         = inc_addr(r_rp);
                n_fill       = r_fill - CW'(1);
            end
            S_MRG: begin
                if (mrg_hit) begin
                    ram_we       = 1'b1;
                    ram_waddr    = wp_last;
                    ram_wdata    = mrg_slot;
                    n_res.status = ST_COALESCED;
                end
            end
            S_PLACE: begin
                if (!fill_full) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_wp;
                    ram_wdata    = r_cmd;
                    n_wp         = inc_addr(r_wp);
                    n_fill       = r_fill + CW'(1);
                    n_res.status = ST_QUEUED;
                end else if (cmd_motion) begin
                    n_res.status = ST_DROPPED;
                end else begin
                    n_k = '0;
                end
            end
            S_SCAN_RD: begin
                ram_raddr = phys(r_rp, r_k);
            end
            S_SCAN_CHK: begin
                if (!slot_motion) begin
                    if (k_next == r_fill) begin
                        // No motion word to evict: latch the first overflow only.
                        if (!r_ovf_pend) begin
                            n_ovf_pend = 1'b1;
                            n_ovf      = r_cmd;
                            n_ovf.value_a = '0;
                            n_ovf.value_b = '0;
                            n_ovf.value_c = '0;
                        end
                        n_res.status = ST_OVERFLOW;
                    end else begin
                        n_k = k_next;
                    end
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = phys(r_rp, k_next);
                if (!(k_next < r_fill)) begin
                    // Compaction done: the new word takes the tail slot.
                    ram_we       = 1'b1;
                    ram_waddr    = phys(r_rp, r_k);
                    ram_wdata    = r_cmd;
                    n_wp         = inc_addr(phys(r_rp, r_k));
                    n_res.status = ST_QUEUED;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_rp, r_k);
                ram_wdata = ram_rdata;
                n_k       = k_next;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rp          <= '0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_k           <= '0;
            r_ovf_pend    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ovf         <= '0;
            r_motion_code <= 8'd0;
            r_ovf_code    <= 8'd1;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_k         <= n_k;
            r_ovf_pend  <= n_ovf_pend;
            r_out_valid <= n_out_valid;
            r_ovf       <= n_ovf;
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    REG_MOTION_KIND:   r_motion_code <= i_cfg.data;
                    REG_OVERFLOW_KIND: r_ovf_code    <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.status            = r_out.status;
    assign o_res.out_kind          = r_out.evt.kind;
    assign o_res.out_flags         = r_out.evt.flags;
    assign o_res.out_source        = r_out.evt.source;
    assign o_res.out_device_kind   = r_out.evt.dev_kind;
    assign o_res.out_device_number = r_out.evt.dev_number;
    assign o_res.out_instance_hash = r_out.evt.hash;
    assign o_res.out_value_a       = r_out.evt.value_a;
    assign o_res.out_value_b       = r_out.evt.value_b;
    assign o_res.out_value_c       = r_out.evt.value_c;
    assign o_res.out_time_us       = r_out.evt.time_us;

endmodule
